// ----- hdl/mfb_pkg.sv -----
// Package: shared constants, codes and types of the monochrome framebuffer.
`timescale 1ns / 1ps
package mfb_pkg;

  localparam int unsigned ScreenWidth  = 288;
  localparam int unsigned ScreenHeight = 64;
  localparam int unsigned RowBytes     = (ScreenWidth + 7) / 8;
  localparam int unsigned StoreBytes   = RowBytes * ScreenHeight;
  localparam int unsigned AddrW        = $clog2(StoreBytes);
  localparam int unsigned ColMax       = (ScreenWidth + 2) / 3 - 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    COL_CLEAR  = 2'd0,
    COL_SET    = 2'd1,
    COL_INVERT = 2'd2,
    COL_KEEP   = 2'd3
  } color_e;

  typedef enum logic [2:0] {
    KIND_DONE   = 3'd0,
    KIND_PIXEL  = 3'd1,
    KIND_HEADER = 3'd2,
    KIND_BYTE   = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW_WB,
    ST_RD_FIN,
    ST_FL_B1,
    ST_FL_B2,
    ST_OUT
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic       pixel_value;
    logic [7:0] display_byte;
    logic [5:0] row_first;
    logic [5:0] row_final;
    logic [6:0] column_first;
    logic [6:0] column_final;
    logic       last;
  } res_t;

  // x / 3 for x < 384 via reciprocal multiply (7-bit result)
  function automatic logic [6:0] div3(input logic [9:0] v);
    logic [19:0] p;
    begin
      p = {10'd0, v} * 20'd683;
      return p[17:11];
    end
  endfunction

endpackage

// ----- hdl/mfb_if.sv -----
// Interfaces: command, result and configuration channels.
`timescale 1ns / 1ps
interface mfb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [1:0]         color;
  modport source (output valid, operation, pos_x, pos_y, color, input ready);
  modport sink (input valid, operation, pos_x, pos_y, color, output ready);
endinterface

interface mfb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       pixel_value;
  logic [7:0] display_byte;
  logic [5:0] row_first;
  logic [5:0] row_final;
  logic [6:0] column_first;
  logic [6:0] column_final;
  logic       last;
  modport source (output valid, kind, pixel_value, display_byte, row_first, row_final,
                  column_first, column_final, last, input ready);
  modport sink (input valid, kind, pixel_value, display_byte, row_first, row_final,
                column_first, column_final, last, output ready);
endinterface

interface mfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hdl/mfb_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module mfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hdl/mono_framebuffer_subpixel_flush.sv -----
// Top level: 1-bit framebuffer with dirty window and 3-pixel-per-byte flush.
`timescale 1ns / 1ps
// Usage
//   in_i  : command words (operation, pos_x, pos_y, color); accepted on valid & ready.
//   out_o : exactly one result word per command, held in an output register.
//   cfg_i : rotation register, always ready; write it only while the block is idle.
// Steps (from acceptance to result register)
//   read / draw  : store byte read, then result load; a draw first writes the modified byte back.
//   flush header, empty, out-of-bounds ops: straight to result load.
//   flush byte   : one store byte read, or two when the three pixels straddle two store bytes.
//   clear        : all 2304 store bytes zeroed, one store byte per cycle, then result load.
//   One command is in work at a time; the single-port store sets the pace.
// Reset
//   After rst_ni rises the store is swept to zero, all 2304 bytes; in_i.ready is low
//   then. The window comes up as the whole screen, rotation 0.
// Stall
//   A finished word waits in the output register; the next command may be accepted
//   and worked, its result waits in a pending register until the slot frees.
module mono_framebuffer_subpixel_flush (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfb_in_if.sink     in_i,
  mfb_out_if.source  out_o,
  mfb_cfg_if.sink    cfg_i
);
  localparam logic [9:0] Width10   = 10'(mfb_pkg::ScreenWidth);
  localparam logic [6:0] Height7   = 7'(mfb_pkg::ScreenHeight);
  localparam logic [6:0] ColMax7   = 7'(mfb_pkg::ColMax);
  localparam logic [mfb_pkg::AddrW-1:0] LastAddr = mfb_pkg::AddrW'(mfb_pkg::StoreBytes - 1);

  mfb_pkg::state_e state_q, state_d;
  logic [1:0]  rot_q;
  // dirty window
  logic [9:0]         left_q, left_d;
  logic [6:0]         top_q, top_d;
  logic signed [10:0] right_q, right_d;
  logic signed [7:0]  bottom_q, bottom_d;
  // flush walk
  logic       active_q, active_d;
  logic [5:0] frow_q, frow_d;
  logic [6:0] fcol_q, fcol_d;
  logic [6:0] cfirst_q, cfirst_d, cfinal_q, cfinal_d;
  // command in work
  logic [mfb_pkg::AddrW-1:0] addr_q, addr_d, clr_q, clr_d;
  logic [2:0]  bit_q, bit_d;
  logic        span_q, span_d;
  logic [1:0]  color_q, color_d;
  logic [7:0]  b0_q, b0_d;
  logic        report_q, report_d;
  mfb_pkg::res_t res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;

  // store port
  logic                      ram_en, ram_we;
  logic [mfb_pkg::AddrW-1:0] ram_addr;
  logic [7:0]                ram_wdata, ram_rdata;

  mfb_ram #(.Width(8), .Depth(mfb_pkg::StoreBytes)) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // rotation map and bounds
  logic signed [15:0] px, py;
  logic        inb;
  logic [9:0]  sx;
  logic [5:0]  sy;
  logic [mfb_pkg::AddrW-1:0] pix_addr;

  assign px = in_i.pos_x;
  assign py = in_i.pos_y;

  always_comb begin
    if (rot_q[0]) begin
      inb = (px >= 0) && (px < 16'sd64) && (py >= 0) && (py < 16'sd288);
    end else begin
      inb = (px >= 0) && (px < 16'sd288) && (py >= 0) && (py < 16'sd64);
    end
    case (rot_q)
      2'd1: begin
        sx = Width10 - 10'd1 - py[9:0];
        sy = px[5:0];
      end
      2'd2: begin
        sx = Width10 - 10'd1 - px[9:0];
        sy = 6'd63 - py[5:0];
      end
      2'd3: begin
        sx = py[9:0];
        sy = 6'd63 - px[5:0];
      end
      default: begin
        sx = px[9:0];
        sy = py[5:0];
      end
    endcase
    pix_addr = mfb_pkg::AddrW'({sy, 5'd0}) + mfb_pkg::AddrW'({sy, 2'd0})
             + mfb_pkg::AddrW'(sx[9:3]);
  end

  // flush byte address
  logic [9:0] x0;
  logic [mfb_pkg::AddrW-1:0] fl_addr;
  assign x0      = {2'b0, fcol_q, 1'b0} + {3'b0, fcol_q};
  assign fl_addr = mfb_pkg::AddrW'({frow_q, 5'd0}) + mfb_pkg::AddrW'({frow_q, 2'd0})
                 + mfb_pkg::AddrW'(x0[9:3]);

  // header
  logic       empty;
  logic [6:0] hd_first, hd_final, lq3;
  logic [6:0] top_cl;
  assign empty    = (left_q >= Width10) || (top_q >= Height7) || (right_q < 0) || (bottom_q < 0);
  assign lq3      = mfb_pkg::div3(left_q);
  assign hd_first = (lq3 > ColMax7) ? ColMax7 : lq3;
  assign hd_final = mfb_pkg::div3(right_q[9:0]);
  assign top_cl   = (top_q > Height7 - 7'd1) ? Height7 - 7'd1 : top_q;

  // flush byte packing
  logic [15:0] w16;
  logic [2:0]  pj;
  logic [7:0]  fbyte;
  always_comb begin
    w16 = (state_q == mfb_pkg::ST_FL_B2) ? {b0_q, ram_rdata} : {ram_rdata, 8'h00};
    for (int j = 0; j < 3; j++) begin
      pj[j] = w16[4'd15 - ({1'b0, bit_q} + 4'(j))];
    end
    fbyte = {{3{pj[0]}}, {3{pj[1]}}, {2{pj[2]}}};
  end

  always_comb begin
    state_d   = state_q;
    left_d    = left_q;
    top_d     = top_q;
    right_d   = right_q;
    bottom_d  = bottom_q;
    active_d  = active_q;
    frow_d    = frow_q;
    fcol_d    = fcol_q;
    cfirst_d  = cfirst_q;
    cfinal_d  = cfinal_q;
    addr_d    = addr_q;
    clr_d     = clr_q;
    bit_d     = bit_q;
    span_d    = span_q;
    color_d   = color_q;
    b0_d      = b0_q;
    report_d  = report_q;
    res_d     = res_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = 8'h00;
    in_i.ready = (state_q == mfb_pkg::ST_IDLE);

    case (state_q)
      mfb_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          res_d = '0;
          color_d = in_i.color;
          bit_d = sx[2:0];
          addr_d = pix_addr;
          case (mfb_pkg::op_e'(in_i.operation))
            mfb_pkg::OP_CLEAR: begin
              clr_d = '0;
              report_d = 1'b1;
              state_d = mfb_pkg::ST_CLEAR;
            end
            mfb_pkg::OP_DRAW: begin
              active_d = 1'b0;
              res_d.kind = mfb_pkg::KIND_DONE;
              if (inb) begin
                if (sx < left_q) left_d = sx;
                if ({1'b0, sy} < top_q) top_d = {1'b0, sy};
                if ($signed({1'b0, sx}) > right_q) right_d = $signed({1'b0, sx});
                if ($signed({2'b0, sy}) > bottom_q) bottom_d = $signed({2'b0, sy});
                ram_en = 1'b1;
                ram_addr = pix_addr;
                state_d = mfb_pkg::ST_DRAW_WB;
              end else begin
                state_d = mfb_pkg::ST_OUT;
              end
            end
            mfb_pkg::OP_READ: begin
              res_d.kind = mfb_pkg::KIND_PIXEL;
              if (inb) begin
                ram_en = 1'b1;
                ram_addr = pix_addr;
                state_d = mfb_pkg::ST_RD_FIN;
              end else begin
                state_d = mfb_pkg::ST_OUT;
              end
            end
            default: begin
              if (active_q) begin
                bit_d = x0[2:0];
                span_d = (x0[2:0] > 3'd5);
                addr_d = fl_addr;
                ram_en = 1'b1;
                ram_addr = fl_addr;
                state_d = mfb_pkg::ST_FL_B1;
              end else if (empty) begin
                res_d.kind = mfb_pkg::KIND_EMPTY;
                state_d = mfb_pkg::ST_OUT;
              end else begin
                top_d = top_cl;
                left_d = {2'b0, hd_first, 1'b0} + {3'd0, hd_first};
                right_d = $signed({3'b0, hd_final, 1'b0} + {4'd0, hd_final} + 11'd2);
                cfirst_d = hd_first;
                cfinal_d = hd_final;
                active_d = 1'b1;
                frow_d = top_cl[5:0];
                fcol_d = hd_first;
                res_d.kind = mfb_pkg::KIND_HEADER;
                res_d.row_first = top_cl[5:0];
                res_d.row_final = bottom_q[5:0];
                res_d.column_first = hd_first;
                res_d.column_final = hd_final;
                state_d = mfb_pkg::ST_OUT;
              end
            end
          endcase
        end
      end
      mfb_pkg::ST_CLEAR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        ram_addr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          left_d = '0;
          top_d = '0;
          right_d = $signed({1'b0, Width10 - 10'd1});
          bottom_d = $signed({1'b0, Height7 - 7'd1});
          active_d = 1'b0;
          res_d = '0;
          res_d.kind = mfb_pkg::KIND_DONE;
          state_d = report_q ? mfb_pkg::ST_OUT : mfb_pkg::ST_IDLE;
        end
      end
      mfb_pkg::ST_DRAW_WB: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        case (mfb_pkg::color_e'(color_q))
          mfb_pkg::COL_SET:    ram_wdata = ram_rdata | (8'h80 >> bit_q);
          mfb_pkg::COL_CLEAR:  ram_wdata = ram_rdata & ~(8'h80 >> bit_q);
          mfb_pkg::COL_INVERT: ram_wdata = ram_rdata ^ (8'h80 >> bit_q);
          default:             ram_wdata = ram_rdata;
        endcase
        state_d = mfb_pkg::ST_OUT;
      end
      mfb_pkg::ST_RD_FIN: begin
        res_d.pixel_value = ram_rdata[3'd7 - bit_q];
        state_d = mfb_pkg::ST_OUT;
      end
      mfb_pkg::ST_FL_B1, mfb_pkg::ST_FL_B2: begin
        if (state_q == mfb_pkg::ST_FL_B1 && span_q) begin
          b0_d = ram_rdata;
          ram_en = 1'b1;
          ram_addr = addr_q + 1'b1;
          state_d = mfb_pkg::ST_FL_B2;
        end else begin
          res_d.kind = mfb_pkg::KIND_BYTE;
          res_d.display_byte = fbyte;
          if (fcol_q >= cfinal_q) begin
            fcol_d = cfirst_q;
            if ($signed({2'b0, frow_q}) >= bottom_q) begin
              res_d.last = 1'b1;
              active_d = 1'b0;
              frow_d = '0;
              fcol_d = '0;
              left_d = Width10;
              top_d = Height7;
              right_d = -11'sd1;
              bottom_d = -8'sd1;
            end else begin
              frow_d = frow_q + 1'b1;
            end
          end else begin
            fcol_d = fcol_q + 1'b1;
          end
          state_d = mfb_pkg::ST_OUT;
        end
      end
      mfb_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = mfb_pkg::ST_IDLE;
        end
      end
      default: state_d = mfb_pkg::ST_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (state_q == mfb_pkg::ST_OUT && (!out_valid_q || out_o.ready)) begin
      out_d = res_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfb_pkg::ST_CLEAR;
      rot_q       <= '0;
      left_q      <= '0;
      top_q       <= '0;
      right_q     <= $signed({1'b0, Width10 - 10'd1});
      bottom_q    <= $signed({1'b0, Height7 - 7'd1});
      active_q    <= 1'b0;
      frow_q      <= '0;
      fcol_q      <= '0;
      clr_q       <= '0;
      report_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_i.valid) rot_q <= cfg_i.data;
      left_q      <= left_d;
      top_q       <= top_d;
      right_q     <= right_d;
      bottom_q    <= bottom_d;
      active_q    <= active_d;
      frow_q      <= frow_d;
      fcol_q      <= fcol_d;
      clr_q       <= clr_d;
      report_q    <= report_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cfirst_q <= cfirst_d;
    cfinal_q <= cfinal_d;
    addr_q   <= addr_d;
    bit_q    <= bit_d;
    span_q   <= span_d;
    color_q  <= color_d;
    b0_q     <= b0_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.pixel_value  = out_q.pixel_value;
  assign out_o.display_byte = out_q.display_byte;
  assign out_o.row_first    = out_q.row_first;
  assign out_o.row_final    = out_q.row_final;
  assign out_o.column_first = out_q.column_first;
  assign out_o.column_final = out_q.column_final;
  assign out_o.last         = out_q.last;

  // store writes only happen during the sweep or a draw write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == mfb_pkg::ST_CLEAR || state_q == mfb_pkg::ST_DRAW_WB))
    else $error("store write outside sweep or draw");
  // no command taken while sweeping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mfb_pkg::ST_CLEAR |-> !in_i.ready)
    else $error("command accepted during sweep");
  // an active flush walks inside its aligned window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (fcol_q >= cfirst_q && fcol_q <= cfinal_q))
    else $error("flush column outside window");
  // an active flush never has an empty window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !empty)
    else $error("flush active on empty window");
endmodule
